// File: src/mvf_pkg.sv
// Shared constants and types for the majority vote finder.
package mvf_pkg;

  // Vote store size and identifier width
  localparam int MAX_VOTES = 64;
  localparam int ID_BITS   = 16;

  // Width of the input and result identifier fields
  localparam int VOTE_W = 16;

  // Store index and vote count widths
  localparam int IDX_W = (MAX_VOTES > 1) ? $clog2(MAX_VOTES) : 1;
  localparam int CNT_W = $clog2(MAX_VOTES + 1);

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   idx_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: src/mvf_ifs.sv
// Valid/ready channel interfaces for vote requests and round results.

interface mvf_in_if;
  logic                           valid;
  logic                           ready;
  logic [mvf_pkg::VOTE_W-1:0]     vote_id;
  logic                           last_vote;

  modport source (output valid, output vote_id, output last_vote, input ready);
  modport sink   (input valid, input vote_id, input last_vote, output ready);
endinterface

interface mvf_out_if;
  logic                           valid;
  logic                           ready;
  logic                           majority_found;
  logic [mvf_pkg::VOTE_W-1:0]     winner_id;
  logic                           overflow;

  modport source (output valid, output majority_found, output winner_id,
                  output overflow, input ready);
  modport sink   (input valid, input majority_found, input winner_id,
                  input overflow, output ready);
endinterface

// File: src/mvf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/majority_vote_finder_unit.sv
// Top level: strict-majority finder over one round of stored votes.
//
// Votes arrive on in_vote, one per request, and are accepted while the block
// is loading: one vote per cycle. Each vote is written to the vote store and
// advances the running candidate and tally. The vote marked last_vote closes
// the round; the block then stops taking requests and rereads every stored
// vote, one store read per cycle through the single read port, counting
// matches with the candidate. After the last read returns and is compared,
// the pass ends and the result is loaded into the output register; an
// overflowed round skips the counting pass and goes straight to loading
// the result.
// The result is held in an output register on out_res until taken. Votes of
// the next round are accepted while it waits; only a round that has finished
// its pass waits, taking no votes, for the register to drain.
// Votes beyond the store size are dropped and the round reports overflow.
// Synchronous reset (rst_n low) starts an empty round and clears the output valid.
module majority_vote_finder_unit (
  input  logic            clk,
  input  logic            rst_n,
  mvf_in_if.sink          in_vote,
  mvf_out_if.source       out_res
);

  mvf_pkg::state_t state_r, state_nxt;

  // Round state
  mvf_pkg::cnt_t total_r, total_nxt;
  mvf_pkg::id_t  cand_r, cand_nxt;
  mvf_pkg::cnt_t tally_r, tally_nxt;
  logic          ovf_r, ovf_nxt;

  // Counting pass
  mvf_pkg::cnt_t addr_r, addr_nxt;
  logic          pend_r, pend_nxt;
  mvf_pkg::cnt_t hits_r, hits_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r, out_found_nxt;
  mvf_pkg::id_t  out_id_r, out_id_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  // Control decoded from state
  logic in_ready;
  logic scanning;
  logic finishing;

  // Store access
  logic          ram_we;
  logic          ram_re;
  mvf_pkg::id_t  ram_rdata;
  mvf_pkg::id_t  vote_v;
  logic          in_acc;
  logic          full;
  logic          issue_more;
  logic          out_free;
  logic          found;
  mvf_pkg::cnt_t tally_step;

  assign vote_v     = in_vote.vote_id[mvf_pkg::ID_BITS-1:0];
  assign in_acc     = in_vote.valid && in_ready;
  assign full       = (total_r == mvf_pkg::cnt_t'(mvf_pkg::MAX_VOTES));
  assign issue_more = (addr_r < total_r);
  assign out_free   = !out_valid_r || out_res.ready;
  assign found      = !ovf_r && (hits_r > (total_r >> 1));

  assign ram_we = in_acc && !full;
  assign ram_re = scanning && issue_more;

  mvf_ram #(
    .WIDTH (mvf_pkg::ID_BITS),
    .DEPTH (mvf_pkg::MAX_VOTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total_r[mvf_pkg::IDX_W-1:0]),
    .wdata (vote_v),
    .re    (ram_re),
    .raddr (addr_r[mvf_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mvf_pkg::ST_LOAD: begin
        if (in_vote.valid && in_vote.last_vote) begin
          state_nxt = ovf_nxt ? mvf_pkg::ST_DONE : mvf_pkg::ST_SCAN;
        end
      end
      mvf_pkg::ST_SCAN: begin
        if (!issue_more && !pend_r) begin
          state_nxt = mvf_pkg::ST_DONE;
        end
      end
      mvf_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = mvf_pkg::ST_LOAD;
        end
      end
      default: state_nxt = mvf_pkg::ST_LOAD;
    endcase
  end

  // State decode
  always_comb begin
    in_ready  = 1'b0;
    scanning  = 1'b0;
    finishing = 1'b0;
    case (state_r)
      mvf_pkg::ST_LOAD: in_ready  = 1'b1;
      mvf_pkg::ST_SCAN: scanning  = 1'b1;
      mvf_pkg::ST_DONE: finishing = out_free;
      default:          in_ready  = 1'b0;
    endcase
  end

  // Boyer-Moore update of candidate and tally per accepted vote
  always_comb begin
    total_nxt  = total_r;
    cand_nxt   = cand_r;
    tally_nxt  = tally_r;
    ovf_nxt    = ovf_r;
    tally_step = (vote_v == cand_r) ? tally_r + 1'b1 : tally_r - 1'b1;
    if (in_acc) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        total_nxt = total_r + 1'b1;
        if (total_r == '0 || tally_step == '0) begin
          cand_nxt  = vote_v;
          tally_nxt = mvf_pkg::cnt_t'(1);
        end else begin
          tally_nxt = tally_step;
        end
      end
    end else if (finishing) begin
      // Result taken into the output register: start a new round
      total_nxt = '0;
      cand_nxt  = '0;
      tally_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  // Counting pass: one read issued per cycle, compare on returned data
  always_comb begin
    addr_nxt = addr_r;
    pend_nxt = 1'b0;
    hits_nxt = hits_r;
    if (in_acc) begin
      addr_nxt = '0;
      hits_nxt = '0;
    end else if (scanning) begin
      pend_nxt = issue_more;
      if (issue_more) begin
        addr_nxt = addr_r + 1'b1;
      end
      if (pend_r && ram_rdata == cand_r) begin
        hits_nxt = hits_r + 1'b1;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_id_nxt    = out_id_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finishing) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found;
      out_id_nxt    = found ? cand_r : '0;
      out_ovf_nxt   = ovf_r;
    end
  end

  // Control and round state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvf_pkg::ST_LOAD;
      total_r     <= '0;
      cand_r      <= '0;
      tally_r     <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      cand_r      <= cand_nxt;
      tally_r     <= tally_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pass counters and result payload
  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    hits_r      <= hits_nxt;
    out_found_r <= out_found_nxt;
    out_id_r    <= out_id_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign in_vote.ready          = in_ready;
  assign out_res.valid          = out_valid_r;
  assign out_res.majority_found = out_found_r;
  assign out_res.winner_id      = mvf_pkg::VOTE_W'(out_id_r);
  assign out_res.overflow       = out_ovf_r;

endmodule

// File: test/majority_vote_finder_unit_checker.sv
// Scoreboard for the majority vote finder: watches both channels, predicts round results.
module majority_vote_finder_unit_checker (
  input  logic clk,
  input  logic rst_n,
  mvf_in_if    vote_mon,
  mvf_out_if   res_mon,
  output int   fail_count,
  output int   results_owed
);

  typedef struct packed {
    logic                       found;
    logic [mvf_pkg::VOTE_W-1:0] winner;
    logic                       ovf;
  } round_verdict_t;

  // Predicted round state
  mvf_pkg::id_t   ballots [mvf_pkg::MAX_VOTES];
  mvf_pkg::cnt_t  ballot_count;
  mvf_pkg::id_t   leader;
  mvf_pkg::cnt_t  lead_margin;
  logic           dropped;
  round_verdict_t verdicts_due [$];
  round_verdict_t want;

  task flag_error(input string msg);
    $display("check: %s at %0t", msg, $time);
    fail_count++;
  endtask

  // Take one vote into the round; on the closing vote work out the verdict
  task count_vote(input mvf_pkg::id_t v, input logic closing);
    int             hits;
    round_verdict_t r;
    if (ballot_count >= mvf_pkg::MAX_VOTES) begin
      dropped = 1'b1;
    end else begin
      ballots[ballot_count[mvf_pkg::IDX_W-1:0]] = v;
      if (ballot_count == '0) begin
        leader      = v;
        lead_margin = mvf_pkg::cnt_t'(1);
      end else begin
        if (v == leader) lead_margin++;
        else lead_margin--;
        if (lead_margin == '0) begin
          leader      = v;
          lead_margin = mvf_pkg::cnt_t'(1);
        end
      end
      ballot_count++;
    end
    if (closing) begin
      hits = 0;
      r    = '0;
      // counting pass only for a round that fitted the store
      if (!dropped && ballot_count > 0) begin
        for (int i = 0; i < ballot_count; i++)
          if (ballots[i] == leader) hits++;
        r.found = (hits > ballot_count / 2);
      end
      if (r.found) r.winner = leader;
      r.ovf = dropped;
      verdicts_due = {verdicts_due, r};
      ballot_count = '0;
      leader       = '0;
      lead_margin  = '0;
      dropped      = 1'b0;
    end
  endtask

  // Check results before taking votes: a result never leaves on its own closing edge
  always @(posedge clk) begin
    if (!rst_n) begin
      ballot_count = '0;
      leader       = '0;
      lead_margin  = '0;
      dropped      = 1'b0;
      fail_count   = 0;
      verdicts_due.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (verdicts_due.size() == 0) begin
          flag_error("result with no round closed");
        end else begin
          want = verdicts_due.pop_front();
          if (res_mon.majority_found !== want.found)
            flag_error($sformatf("majority_found %b, want %b",
                                 res_mon.majority_found, want.found));
          if (res_mon.winner_id !== want.winner)
            flag_error($sformatf("winner_id %h, want %h",
                                 res_mon.winner_id, want.winner));
          if (res_mon.overflow !== want.ovf)
            flag_error($sformatf("overflow %b, want %b",
                                 res_mon.overflow, want.ovf));
        end
      end
      if (vote_mon.valid && vote_mon.ready)
        count_vote(vote_mon.vote_id[mvf_pkg::ID_BITS-1:0], vote_mon.last_vote);
    end
    results_owed = verdicts_due.size();
  end

endmodule

// File: test/majority_vote_finder_unit_test.sv
// Testbench top for the majority vote finder: clock, reset, vote rounds and verdict.
module majority_vote_finder_unit_test;

  localparam int VOTE_TARGET = 450;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_SPARSE,
    DRAIN_PERIODIC
  } drain_mode_t;

  logic         clk;
  logic         rst_n;
  int           fail_count;
  int           results_owed;
  int           cycle_count;
  int           votes_sent;
  int           burst_left;
  mvf_pkg::id_t ballot_q [$];

  mvf_in_if  vote_ch ();
  mvf_out_if res_ch ();

  majority_vote_finder_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vote (vote_ch),
    .out_res (res_ch)
  );

  majority_vote_finder_unit_checker scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .vote_mon     (vote_ch),
    .res_mon      (res_ch),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one vote request, with a random gap at the start of each burst
  task send_vote(input mvf_pkg::id_t v, input logic closing);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        vote_ch.valid     = 1'b0;
        vote_ch.vote_id   = mvf_pkg::VOTE_W'($urandom);
        vote_ch.last_vote = 1'($urandom_range(0, 1));
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    vote_ch.valid     = 1'b1;
    vote_ch.vote_id   = v;
    vote_ch.last_vote = closing;
    @(posedge clk);
    while (!vote_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    votes_sent++;
  endtask

  // Send the queued ballots as one round, last one closing it
  task cast_round();
    for (int i = 0; i < ballot_q.size(); i++)
      send_vote(ballot_q[i], i == ballot_q.size() - 1);
  endtask

  // Random round: mostly small, now and then full or overflowing the store
  task random_round();
    int           n;
    int           pool_n;
    int           lean;
    mvf_pkg::id_t pool [4];
    ballot_q.delete();
    case ($urandom_range(0, 19))
      0:       n = mvf_pkg::MAX_VOTES;
      1:       n = mvf_pkg::MAX_VOTES + $urandom_range(1, 6);
      2:       n = $urandom_range(40, mvf_pkg::MAX_VOTES - 1);
      default: n = $urandom_range(1, 12);
    endcase
    pool_n = $urandom_range(1, 4);
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 7))
        0:       pool[k] = '0;
        1:       pool[k] = '1;
        default: pool[k] = mvf_pkg::id_t'($urandom);
      endcase
    end
    lean = $urandom_range(0, 100);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < lean) ballot_q = {ballot_q, pool[0]};
      else if ($urandom_range(0, 9) == 0) ballot_q = {ballot_q, mvf_pkg::id_t'($urandom)};
      else ballot_q = {ballot_q, pool[$urandom_range(0, pool_n - 1)]};
    end
    cast_round();
  endtask

  // Stimulus and verdict
  initial begin
    rst_n             = 1'b0;
    vote_ch.valid     = 1'b0;
    vote_ch.vote_id   = '0;
    vote_ch.last_vote = 1'b0;
    burst_left        = 0;
    votes_sent        = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single vote rounds at both ends of the identifier range
    ballot_q = '{16'h0000};
    cast_round();
    ballot_q = '{16'hFFFF};
    cast_round();
    // two-way tie, no majority
    ballot_q = '{16'h1234, 16'h5678};
    cast_round();
    // alternating bits, two against one
    ballot_q = '{16'hAAAA, 16'h5555, 16'hAAAA};
    cast_round();
    // candidate survives to the end but is no majority
    ballot_q = '{16'h0001, 16'h0001, 16'h0002, 16'h0002, 16'h0003};
    cast_round();
    // three of four
    ballot_q = '{16'h0007, 16'h0007, 16'h0007, 16'h0008};
    cast_round();
    // candidate replaced mid-round, winner comes late
    ballot_q = '{16'h0001, 16'h0002, 16'h0003, 16'h0003, 16'h0003};
    cast_round();
    // even split, exactly half is not enough
    ballot_q = '{16'h0005, 16'h0005, 16'h0009, 16'h0009};
    cast_round();

    while (votes_sent < VOTE_TARGET) random_round();

    vote_ch.valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (2 * mvf_pkg::MAX_VOTES + 20) @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result receiver: stall pattern changes every so often
  initial begin
    drain_mode_t mode;
    int          span;
    int          tick;
    res_ch.ready = 1'b0;
    tick         = 0;
    forever begin
      mode = drain_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          DRAIN_FREE:     res_ch.ready = 1'b1;
          DRAIN_COIN:     res_ch.ready = 1'($urandom_range(0, 1));
          DRAIN_SPARSE:   res_ch.ready = ($urandom_range(0, 3) == 0);
          DRAIN_PERIODIC: res_ch.ready = (tick % 5 != 0);
          default:        res_ch.ready = 1'b1;
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
